[hdl/arprt_pkg.sv]
// ----------------------------------------------------------------------------
// arprt_pkg
// Shared types and constants for the ARP request/reply tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package arprt_pkg;

    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 48;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 32;
    localparam int ENTRY_W = 5;

    localparam logic [CFG_W-1:0] TIMEOUT_RST = 32'd1000000;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_REQ = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWP = 2'd2;

    // token walking the cell row
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] dest_ip;
        logic [TIME_W-1:0] time_us;
        logic              found;      // pending entry for target already hit
        logic              claimed;    // a free cell took the request tentatively
        logic [TIME_W-1:0] latency_us;
    } tok_t;

    // end-of-walk decision broadcast to all cells
    typedef struct packed {
        logic valid;
        logic keep;                    // 1: tentative entry becomes occupied
    } commit_t;

endpackage

`default_nettype wire

[hdl/arprt_cell.sv]
// ----------------------------------------------------------------------------
// arprt_cell
// One table entry; updates itself from the passing token and forwards it.
// ----------------------------------------------------------------------------
`default_nettype none

module arprt_cell
    import arprt_pkg::*;
#(
    parameter int CW = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tok_t             tok_i,
    input  logic [CW-1:0]    used_i,
    input  logic [CW-1:0]    tmo_i,
    input  commit_t          commit_i,
    input  logic [CFG_W-1:0] timeout_us_i,
    output tok_t             tok_o,
    output logic [CW-1:0]    used_o,
    output logic [CW-1:0]    tmo_o
);

    logic              occ_reg, occ_next;
    logic              pend_reg, pend_next;
    logic              ans_reg, ans_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [TIME_W-1:0] stamp_reg, stamp_next;
    tok_t              tok_reg, tok_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [CW-1:0]     tmo_reg, tmo_next;

    logic [TIME_W:0]   diff;
    logic              later;
    logic              expired;
    logic              hit;
    logic              tmo_inc;

    always_comb begin
        diff    = {1'b0, tok_i.time_us} - {1'b0, stamp_reg};
        later   = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
        expired = later &&
                  (diff[TIME_W-1:0] > {{(TIME_W-CFG_W){1'b0}}, timeout_us_i});
        hit     = tok_i.valid && occ_reg && !ans_reg && !tok_i.found &&
                  (addr_reg == tok_i.dest_ip);

        occ_next   = occ_reg;
        pend_next  = pend_reg;
        ans_next   = ans_reg;
        addr_next  = addr_reg;
        stamp_next = stamp_reg;
        tok_next   = tok_i;
        tmo_inc    = 1'b0;

        if (commit_i.valid && pend_reg) begin
            occ_next  = commit_i.keep;
            pend_next = 1'b0;
        end

        if (tok_i.valid) begin
            unique case (tok_i.kind)
                KIND_REQ: begin
                    if (hit) begin
                        stamp_next     = tok_i.time_us;
                        tok_next.found = 1'b1;
                    end else if (!occ_reg && !pend_reg && !tok_i.claimed &&
                                 !tok_i.found) begin
                        // held tentatively until the walk shows no match further on
                        pend_next        = 1'b1;
                        ans_next         = 1'b0;
                        addr_next        = tok_i.dest_ip;
                        stamp_next       = tok_i.time_us;
                        tok_next.claimed = 1'b1;
                    end
                end
                KIND_REP: begin
                    if (hit) begin
                        ans_next            = 1'b1;
                        tok_next.found      = 1'b1;
                        tok_next.latency_us = later ? diff[TIME_W-1:0] : '0;
                    end
                end
                KIND_SWP: begin
                    if (occ_reg) begin
                        if (ans_reg) begin
                            occ_next = 1'b0;
                        end else if (expired) begin
                            occ_next = 1'b0;
                            tmo_inc  = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        used_next = used_i + CW'(occ_next | pend_next);
        tmo_next  = tmo_i + CW'(tmo_inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg  <= 1'b0;
            pend_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            occ_reg  <= occ_next;
            pend_reg <= pend_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        ans_reg   <= ans_next;
        addr_reg  <= addr_next;
        stamp_reg <= stamp_next;
        used_reg  <= used_next;
        tmo_reg   <= tmo_next;
    end

    assign tok_o  = tok_reg;
    assign used_o = used_reg;
    assign tmo_o  = tmo_reg;

endmodule

`default_nettype wire

[hdl/arp_request_reply_tracker.sv]
// ----------------------------------------------------------------------------
// arp_request_reply_tracker
// Pending ARP request table with reply latency and timeout sweeping.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake             payload
//  s_        in    s_valid / s_ready     kind, dest_ip, time_us
//  m_        out   m_valid / m_ready     reply_matched, latency_us, 4 counters,
//                                        entries_in_use
//  cfg_      in    cfg_we (no wait)      cfg_wdata -> timeout_us
//
//  One word is in flight at a time. A token carrying the word walks the row
//  of PENDING_ENTRIES cells, one cell per cycle, and s_ready returns when
//  the token leaves the last cell. The result lands in an output register; if
//  that register is still full, the result is parked and s_ready returns once
//  it moves out. Reset (aresetn low, synchronous) empties the table, zeroes
//  the counters and sets timeout_us to 1000000.
//
`default_nettype none

module arp_request_reply_tracker
    import arprt_pkg::*;
#(
    parameter int PENDING_ENTRIES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [KIND_W-1:0]  s_kind,
    input  logic [ADDR_W-1:0]  s_dest_ip,
    input  logic [TIME_W-1:0]  s_time_us,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_reply_matched,
    output logic [TIME_W-1:0]  m_latency_us,
    output logic [CNT_W-1:0]   m_request_count,
    output logic [CNT_W-1:0]   m_reply_count,
    output logic [CNT_W-1:0]   m_matched_count,
    output logic [CNT_W-1:0]   m_timeout_count,
    output logic [ENTRY_W-1:0] m_entries_in_use
);

    localparam int CW = $clog2(PENDING_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CFG_W-1:0]   timeout_reg;
    tok_t               head_reg, head_next;

    logic [CNT_W-1:0]   req_cnt_reg, req_cnt_next;
    logic [CNT_W-1:0]   rep_cnt_reg, rep_cnt_next;
    logic [CNT_W-1:0]   mat_cnt_reg, mat_cnt_next;
    logic [CNT_W-1:0]   tmo_cnt_reg, tmo_cnt_next;

    // parked result while the output register is occupied
    logic               hold_mat_reg, hold_mat_next;
    logic [TIME_W-1:0]  hold_lat_reg, hold_lat_next;
    logic [CW-1:0]      hold_used_reg, hold_used_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_mat_reg, m_mat_next;
    logic [TIME_W-1:0]  m_lat_reg, m_lat_next;
    logic [CNT_W-1:0]   m_req_reg, m_req_next;
    logic [CNT_W-1:0]   m_rep_reg, m_rep_next;
    logic [CNT_W-1:0]   m_matc_reg, m_matc_next;
    logic [CNT_W-1:0]   m_tmo_reg, m_tmo_next;
    logic [ENTRY_W-1:0] m_used_reg, m_used_next;

    tok_t               tok_w  [0:PENDING_ENTRIES];
    logic [CW-1:0]      used_w [0:PENDING_ENTRIES];
    logic [CW-1:0]      tmo_w  [0:PENDING_ENTRIES];
    commit_t            commit;

    tok_t               fin;
    logic               accept;
    logic               out_free;
    logic               fin_mat;
    logic [CW-1:0]      fin_used;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // --- cell row ---
    assign tok_w[0]  = head_reg;
    assign used_w[0] = '0;
    assign tmo_w[0]  = '0;

    for (genvar g = 0; g < PENDING_ENTRIES; g++) begin : g_cell
        arprt_cell #(
            .CW(CW)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .tok_i        (tok_w[g]),
            .used_i       (used_w[g]),
            .tmo_i        (tmo_w[g]),
            .commit_i     (commit),
            .timeout_us_i (timeout_reg),
            .tok_o        (tok_w[g+1]),
            .used_o       (used_w[g+1]),
            .tmo_o        (tmo_w[g+1])
        );
    end

    // token leaving the last cell
    assign fin = tok_w[PENDING_ENTRIES];

    // a request that found its target drops the tentative free-cell claim
    assign commit.valid = fin.valid;
    assign commit.keep  = !fin.found;

    assign fin_mat  = fin.found && (fin.kind == KIND_REP);
    assign fin_used = used_w[PENDING_ENTRIES] - CW'(fin.found && fin.claimed);

    always_comb begin
        head_next         = '0;
        head_next.valid   = accept;
        head_next.kind    = s_kind;
        head_next.dest_ip = s_dest_ip;
        head_next.time_us = s_time_us;

        state_next     = state_reg;
        req_cnt_next   = req_cnt_reg;
        rep_cnt_next   = rep_cnt_reg;
        mat_cnt_next   = mat_cnt_reg;
        tmo_cnt_next   = tmo_cnt_reg;
        hold_mat_next  = hold_mat_reg;
        hold_lat_next  = hold_lat_reg;
        hold_used_next = hold_used_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_mat_next   = m_mat_reg;
        m_lat_next   = m_lat_reg;
        m_req_next   = m_req_reg;
        m_rep_next   = m_rep_reg;
        m_matc_next  = m_matc_reg;
        m_tmo_next   = m_tmo_reg;
        m_used_next  = m_used_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (fin.valid) begin
                    req_cnt_next = req_cnt_reg + CNT_W'(fin.kind == KIND_REQ);
                    rep_cnt_next = rep_cnt_reg + CNT_W'(fin.kind == KIND_REP);
                    mat_cnt_next = mat_cnt_reg + CNT_W'(fin_mat);
                    tmo_cnt_next = tmo_cnt_reg + CNT_W'(tmo_w[PENDING_ENTRIES]);
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_mat_next   = fin_mat;
                        m_lat_next   = fin_mat ? fin.latency_us : '0;
                        m_req_next   = req_cnt_next;
                        m_rep_next   = rep_cnt_next;
                        m_matc_next  = mat_cnt_next;
                        m_tmo_next   = tmo_cnt_next;
                        m_used_next  = ENTRY_W'(fin_used);
                        state_next   = ST_IDLE;
                    end else begin
                        hold_mat_next  = fin_mat;
                        hold_lat_next  = fin_mat ? fin.latency_us : '0;
                        hold_used_next = fin_used;
                        state_next     = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                // counters cannot move while parked, so they are read directly
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_mat_next   = hold_mat_reg;
                    m_lat_next   = hold_lat_reg;
                    m_req_next   = req_cnt_reg;
                    m_rep_next   = rep_cnt_reg;
                    m_matc_next  = mat_cnt_reg;
                    m_tmo_next   = tmo_cnt_reg;
                    m_used_next  = ENTRY_W'(hold_used_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            timeout_reg <= TIMEOUT_RST;
            head_reg    <= '0;
            req_cnt_reg <= '0;
            rep_cnt_reg <= '0;
            mat_cnt_reg <= '0;
            tmo_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            head_reg    <= head_next;
            req_cnt_reg <= req_cnt_next;
            rep_cnt_reg <= rep_cnt_next;
            mat_cnt_reg <= mat_cnt_next;
            tmo_cnt_reg <= tmo_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_mat_reg  <= hold_mat_next;
        hold_lat_reg  <= hold_lat_next;
        hold_used_reg <= hold_used_next;
        m_mat_reg     <= m_mat_next;
        m_lat_reg     <= m_lat_next;
        m_req_reg     <= m_req_next;
        m_rep_reg     <= m_rep_next;
        m_matc_reg    <= m_matc_next;
        m_tmo_reg     <= m_tmo_next;
        m_used_reg    <= m_used_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_reply_matched  = m_mat_reg;
    assign m_latency_us     = m_lat_reg;
    assign m_request_count  = m_req_reg;
    assign m_reply_count    = m_rep_reg;
    assign m_matched_count  = m_matc_reg;
    assign m_timeout_count  = m_tmo_reg;
    assign m_entries_in_use = m_used_reg;

endmodule

`default_nettype wire

[hdl/arprt_checker.sv]
// ----------------------------------------------------------------------------
// arprt_checker
// Port-level assertions for the ARP request/reply tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module arprt_checker #(
    parameter int PENDING_ENTRIES = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_reply_matched,
    input logic [47:0] m_latency_us,
    input logic [31:0] m_request_count,
    input logic [4:0]  m_entries_in_use
);

    // one word in flight: ready drops after every acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after an accepted word");

    // stalled result holds
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_latency_us) &&
                                $stable(m_request_count))
        else $error("stalled result word changed");

    // latency is reported only for matched replies
    a_latency_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reply_matched |-> m_latency_us == '0)
        else $error("latency non-zero on unmatched result");

    // occupancy never exceeds the table size
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_entries_in_use) <= PENDING_ENTRIES)
        else $error("entries_in_use beyond table size");

endmodule

bind arp_request_reply_tracker arprt_checker #(
    .PENDING_ENTRIES(PENDING_ENTRIES)
) u_arprt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_reply_matched  (m_reply_matched),
    .m_latency_us     (m_latency_us),
    .m_request_count  (m_request_count),
    .m_entries_in_use (m_entries_in_use)
);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARP request/reply tracker: a short table of
// hand-picked words, then random phases at several timeout settings, with
// every result word checked against its written-out report or a cycle-free model of the pending table.
// ----------------------------------------------------------------------------

module testbench;

    import arprt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_POOL   = 20;      // a little more than the table holds
    localparam int CYCLE_LIMIT = 500000;
    localparam int SHOW_FAULTS = 10;

    // the one code the package leaves out: a word the block must ignore
    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

    localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

    typedef struct packed {
        logic               matched;
        logic [TIME_W-1:0]  latency;
        logic [CNT_W-1:0]   requests;
        logic [CNT_W-1:0]   replies;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   timeouts;
        logic [ENTRY_W-1:0] in_use;
    } arp_report_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] ip;
        logic [TIME_W-1:0] stamp;
        bit                typed;     // report written out by hand
        arp_report_t       want;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [KIND_W-1:0]  s_kind;
    logic [ADDR_W-1:0]  s_dest_ip;
    logic [TIME_W-1:0]  s_time_us;
    logic               m_valid;
    logic               m_ready;
    logic               m_reply_matched;
    logic [TIME_W-1:0]  m_latency_us;
    logic [CNT_W-1:0]   m_request_count;
    logic [CNT_W-1:0]   m_reply_count;
    logic [CNT_W-1:0]   m_matched_count;
    logic [CNT_W-1:0]   m_timeout_count;
    logic [ENTRY_W-1:0] m_entries_in_use;

    // single config register, so cfg index 0 is implied by cfg_we
    arp_request_reply_tracker #(
        .PENDING_ENTRIES (TABLE_DEPTH)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_dest_ip        (s_dest_ip),
        .s_time_us        (s_time_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_reply_matched  (m_reply_matched),
        .m_latency_us     (m_latency_us),
        .m_request_count  (m_request_count),
        .m_reply_count    (m_reply_count),
        .m_matched_count  (m_matched_count),
        .m_timeout_count  (m_timeout_count),
        .m_entries_in_use (m_entries_in_use)
    );

    // ------------------------------------------------------------------------
    // Clock, 10 ns period
    // ------------------------------------------------------------------------
    initial aclk = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the pending table and counters
    // ------------------------------------------------------------------------
    logic              slot_busy   [TABLE_DEPTH];
    logic              slot_done   [TABLE_DEPTH];
    logic [ADDR_W-1:0] slot_ip     [TABLE_DEPTH];
    logic [TIME_W-1:0] slot_stamp  [TABLE_DEPTH];
    logic [CNT_W-1:0]  tally_req;
    logic [CNT_W-1:0]  tally_rep;
    logic [CNT_W-1:0]  tally_match;
    logic [CNT_W-1:0]  tally_tmo;
    logic [CFG_W-1:0]  timeout_setting;

    arp_report_t       due_reports [$];   // one per word sent, oldest first
    int                faults;
    int                cycles;
    bit                calm;              // no idling on either side while set
    int                rx_hold;           // cycles left of the current m_ready stall
    logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
    logic [TIME_W-1:0] clock_us;          // running time base of a random phase
    plan_row_t         plan [$];

    // Apply one word to the shadow table and return the report it gives.
    function automatic arp_report_t track_word(input logic [KIND_W-1:0] kind,
                                               input logic [ADDR_W-1:0] ip,
                                               input logic [TIME_W-1:0] now);
        arp_report_t res;
        int          hit;
        int          i;
        int          busy;
        res  = '0;
        hit  = -1;
        busy = 0;
        // at most one unanswered entry per target, so first hit is the hit
        for (i = 0; i < TABLE_DEPTH; i++)
            if (hit < 0 && slot_busy[i] && !slot_done[i] && slot_ip[i] == ip)
                hit = i;
        case (kind)
            KIND_REQ: begin
                tally_req++;
                if (hit >= 0) begin
                    slot_stamp[hit] = now;
                end else begin
                    // lowest free slot; a full table drops the request
                    for (i = 0; i < TABLE_DEPTH; i++) begin
                        if (hit < 0 && !slot_busy[i]) begin
                            hit           = i;
                            slot_busy[i]  = 1'b1;
                            slot_done[i]  = 1'b0;
                            slot_ip[i]    = ip;
                            slot_stamp[i] = now;
                        end
                    end
                end
            end
            KIND_REP: begin
                tally_rep++;
                if (hit >= 0) begin
                    slot_done[hit] = 1'b1;
                    tally_match++;
                    res.matched = 1'b1;
                    // reply before request saturates at zero
                    if (now > slot_stamp[hit])
                        res.latency = now - slot_stamp[hit];
                end
            end
            KIND_SWP: begin
                for (i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_busy[i]) begin
                        if (slot_done[i]) begin
                            slot_busy[i] = 1'b0;
                        end else if (now > slot_stamp[i] &&
                                     (now - slot_stamp[i]) >
                                     {{(TIME_W-CFG_W){1'b0}}, timeout_setting}) begin
                            slot_busy[i] = 1'b0;
                            tally_tmo++;
                        end
                    end
                end
            end
            default: ;  // unknown kind leaves everything alone
        endcase
        for (i = 0; i < TABLE_DEPTH; i++)
            if (slot_busy[i])
                busy++;
        res.requests = tally_req;
        res.replies  = tally_rep;
        res.hits     = tally_match;
        res.timeouts = tally_tmo;
        res.in_use   = ENTRY_W'(busy);
        return res;
    endfunction

    function automatic arp_report_t report_of(input logic m, input logic [TIME_W-1:0] lat,
                                              input int rq, input int rp, input int mt,
                                              input int to, input int used);
        arp_report_t r;
        r = '{m, lat, CNT_W'(rq), CNT_W'(rp), CNT_W'(mt), CNT_W'(to), ENTRY_W'(used)};
        return r;
    endfunction

    function automatic void add_row(input logic [KIND_W-1:0] kind,
                                    input logic [ADDR_W-1:0] ip,
                                    input logic [TIME_W-1:0] stamp);
        plan.push_back('{kind, ip, stamp, 1'b0, arp_report_t'('0)});
    endfunction

    function automatic void add_typed(input logic [KIND_W-1:0] kind,
                                      input logic [ADDR_W-1:0] ip,
                                      input logic [TIME_W-1:0] stamp,
                                      input arp_report_t want);
        plan.push_back('{kind, ip, stamp, 1'b1, want});
    endfunction

    // Idle length: mostly none, some short, a few long enough to park results.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic void note_fault(input string what, input arp_report_t want,
                                       input arp_report_t seen);
        faults++;
        if (faults <= SHOW_FAULTS) begin
            $display("%0t ns: %s", $time, what);
            $display("  exp m=%0d lat=%0h req=%0d rep=%0d mat=%0d tmo=%0d use=%0d",
                     want.matched, want.latency, want.requests, want.replies,
                     want.hits, want.timeouts, want.in_use);
            $display("  got m=%0d lat=%0h req=%0d rep=%0d mat=%0d tmo=%0d use=%0d",
                     seen.matched, seen.latency, seen.requests, seen.replies,
                     seen.hits, seen.timeouts, seen.in_use);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Called at a clock edge; returns at the edge where the word is taken.
    // Valid stays up between back-to-back words, dropped only for a gap.
    task automatic send_word(input plan_row_t row);
        int          gap;
        arp_report_t guess;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= row.kind;
        s_dest_ip <= row.ip;
        s_time_us <= row.stamp;
        guess = track_word(row.kind, row.ip, row.stamp);
        due_reports.push_back(row.typed ? row.want : guess);
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Drain, let the block settle, then write timeout_us.
    task automatic write_timeout(input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we          <= 1'b0;
        timeout_setting  = value;
    endtask

    // One random phase. Mostly requests and replies over a small address pool
    // with time creeping forward, plus some sweeps, so the table fills, matches
    // and ages; the rest is noise: unknown kinds, stray addresses, wild or backward times.
    task automatic run_phase(input int count, input logic [CFG_W-1:0] tmo,
                             input int unsigned step);
        int        n;
        int        r;
        plan_row_t row;
        write_timeout(tmo);
        clock_us = {16'($urandom), 32'($urandom)};
        for (n = 0; n < count; n++) begin
            if (n % 30 == 0)
                calm = ($urandom_range(0, 3) == 0);
            clock_us  += TIME_W'($urandom_range(0, step));
            row        = '{KIND_REQ, addr_pool[$urandom_range(0, ADDR_POOL-1)],
                           clock_us, 1'b0, arp_report_t'('0)};
            r          = $urandom_range(0, 99);
            if (r < 45) begin
                row.kind = KIND_REQ;
            end else if (r < 80) begin
                row.kind = KIND_REP;
            end else if (r < 90) begin
                row.kind = KIND_SWP;
            end else begin
                row.kind = KIND_W'($urandom_range(0, 2));
                case ($urandom_range(0, 3))
                    0: begin
                        row.kind  = KIND_BAD;
                        row.ip    = $urandom;
                        row.stamp = {16'($urandom), 32'($urandom)};
                    end
                    1: row.ip    = $urandom;
                    2: row.stamp = {16'($urandom), 32'($urandom)};
                    default: row.stamp = clock_us - TIME_W'($urandom_range(0, 4 * step + 4));
                endcase
            end
            send_word(row);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, then check against the oldest report
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            // a stall drawn right after a take lands on the next result
            if (m_valid && m_ready)
                rx_hold <= idle_len();
            else if (!calm && $urandom_range(0, 15) == 0)
                rx_hold <= $urandom_range(1, 4);
        end
    end

    always @(posedge aclk) begin
        arp_report_t seen;
        arp_report_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_reply_matched, m_latency_us, m_request_count, m_reply_count,
                    m_matched_count, m_timeout_count, m_entries_in_use};
            if (due_reports.size() == 0) begin
                note_fault("result word with nothing expected", '0, seen);
            end else begin
                want = due_reports.pop_front();
                if (seen.matched !== want.matched || seen.latency !== want.latency ||
                    seen.requests !== want.requests || seen.replies !== want.replies ||
                    seen.hits !== want.hits || seen.timeouts !== want.timeouts ||
                    seen.in_use !== want.in_use)
                    note_fault("result word mismatch", want, seen);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int i;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_kind      = KIND_REQ;
        s_dest_ip   = '0;
        s_time_us   = '0;
        m_ready     = 1'b0;
        faults      = 0;
        cycles      = 0;
        calm        = 1'b0;
        rx_hold     = 0;
        clock_us    = '0;
        tally_req   = '0;
        tally_rep   = '0;
        tally_match = '0;
        tally_tmo   = '0;
        timeout_setting = TIMEOUT_RST;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            slot_busy[i]  = 1'b0;
            slot_done[i]  = 1'b0;
            slot_ip[i]    = '0;
            slot_stamp[i] = '0;
        end
        addr_pool[0] = '0;
        addr_pool[1] = ADDR_TOP;
        for (i = 2; i < ADDR_POOL; i++)
            addr_pool[i] = $urandom;

        // Directed words. Early rows have their reports written out; the
        // counters are easy to follow by hand from an empty table.
        add_typed(KIND_BAD, ADDR_TOP, TIME_TOP, report_of(0, 0, 0, 0, 0, 0, 0));
        add_typed(KIND_REP, '0, '0, report_of(0, 0, 0, 1, 0, 0, 0));  // reply, empty
        add_typed(KIND_SWP, '0, TIME_TOP, report_of(0, 0, 0, 1, 0, 0, 0));
        add_typed(KIND_REQ, '0, 48'd100, report_of(0, 0, 1, 1, 0, 0, 1));
        add_typed(KIND_REQ, ADDR_TOP, '0, report_of(0, 0, 2, 1, 0, 0, 2));
        add_typed(KIND_REQ, '0, 48'd200, report_of(0, 0, 3, 1, 0, 0, 2));  // refresh
        // reply earlier than the refreshed stamp: matched, latency zero
        add_typed(KIND_REP, '0, 48'd150, report_of(1, 0, 3, 2, 1, 0, 2));
        // widest latency the field can hold
        add_typed(KIND_REP, ADDR_TOP, TIME_TOP, report_of(1, TIME_TOP, 3, 3, 2, 0, 2));
        add_row(KIND_REP, '0, 48'd300);          // already answered: no match
        add_row(KIND_SWP, '0, 48'd50);           // frees both answered entries
        for (i = 0; i < TABLE_DEPTH; i++)
            add_row(KIND_REQ, 32'h0A00_0001 + i, 48'd1000 + i);
        add_row(KIND_REQ, 32'hC0A8_0001, 48'd2000);  // table full: dropped
        add_row(KIND_SWP, '0, TIME_TOP);         // everything times out

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k])
            send_word(plan[k]);

        // random phases: a timeout of one, the largest, a mid value, reset value
        // and an arbitrary one, each with a time step to match
        run_phase(90, 32'd1, 3);
        run_phase(90, ADDR_TOP, 5000);
        run_phase(90, CFG_W'($urandom_range(64, 4096)), 600);
        run_phase(90, TIMEOUT_RST, 200000);
        run_phase(90, $urandom, 32'h4000_0000);

        s_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (faults == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hdl/arprt_pkg.sv
hdl/arprt_cell.sv
hdl/arp_request_reply_tracker.sv
hdl/arprt_checker.sv
test/testbench.sv
